// File: rtl/core/gbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbf_pkg;

   localparam int FRAME_COLUMNS     = 84;
   localparam int FRAME_BANKS       = 6;
   localparam int GLYPH_STORE_DEPTH = 768;

   localparam int FRAME_ROWS  = FRAME_BANKS * 8;
   localparam int FRAME_WORDS = FRAME_BANKS * FRAME_COLUMNS;
   localparam int FADDR_W     = $clog2(FRAME_WORDS);
   localparam int GLYPH_AW    = $clog2(GLYPH_STORE_DEPTH);
   // glyph base (code - 32) * stride plus index, up to 95 * 15 + 14
   localparam int GBASE_W     = 12;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_RETURN  = 8'd13;
   localparam logic [7:0] CHAR_FIRST   = 8'd32;
   localparam logic [7:0] CHAR_LAST    = 8'd127;

   localparam logic [15:0] MASK_WORD = 16'hFF00;

   localparam logic [2:0] CSR_DRAW_MODE   = 3'd0;
   localparam logic [2:0] CSR_GLYPH_WIDTH = 3'd1;
   localparam logic [2:0] CSR_GLYPH_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_GLYPH_ORIENT = 3'd3;

   typedef enum logic [2:0] {
      KIND_CHAR   = 3'd0,
      KIND_LOAD   = 3'd1,
      KIND_CLEAR  = 3'd2,
      KIND_CURSOR = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GATHER,
      ST_COL,
      ST_WR_HI,
      ST_WR_LO,
      ST_DIV,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                en;
      logic [GLYPH_AW-1:0] addr;
      logic [7:0]          data;
   } glyph_load_type;

   typedef struct packed {
      logic       start;
      logic       orient;
      logic [6:0] code_ofs;
      logic [3:0] width;
      logic [3:0] height;
   } gather_cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/gbf_glyph_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module gbf_glyph_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gbf_pkg::glyph_load_type load,
   input  wire gbf_pkg::gather_cmd_type cmd,
   input  wire logic [3:0]              col_sel,
   output logic                         done,
   output logic [15:0]                  col_word
);

   logic [7:0] glyph_mem [gbf_pkg::GLYPH_STORE_DEPTH];
   logic [7:0] q_ff;

   logic                        active_ff;
   logic                        rv_ff;
   logic                        orient_ff;
   logic [gbf_pkg::GBASE_W-1:0] base_ff;
   logic [3:0]                  total_ff;
   logic [3:0]                  k_ff;
   logic [3:0]                  rk_ff;
   logic                        rin_ff;
   logic [15:0]                 cols_ff [16];

   logic                        issue;
   logic [gbf_pkg::GBASE_W-1:0] addr;
   logic                        in_rng;
   logic [3:0]                  stride;
   logic [7:0]                  byte_val;

   always_comb begin
      issue    = active_ff && (k_ff != total_ff);
      addr     = base_ff + gbf_pkg::GBASE_W'(k_ff);
      in_rng   = addr < gbf_pkg::GBASE_W'(gbf_pkg::GLYPH_STORE_DEPTH);
      done     = active_ff && !issue && !rv_ff;
      stride   = cmd.orient ? cmd.height : cmd.width;
      byte_val = rin_ff ? q_ff : 8'h00;
      col_word = cols_ff[col_sel];
   end

   always_ff @(posedge clock) begin
      if (load.en) begin
         glyph_mem[load.addr] <= load.data;
      end
      if (issue && in_rng) begin
         q_ff <= glyph_mem[addr[gbf_pkg::GLYPH_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         if (cmd.start) begin
            active_ff <= 1'b1;
         end else if (done) begin
            active_ff <= 1'b0;
         end
         rv_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         orient_ff <= cmd.orient;
         base_ff   <= gbf_pkg::GBASE_W'(cmd.code_ofs) * gbf_pkg::GBASE_W'(stride);
         total_ff  <= stride;
         k_ff      <= 4'd0;
         for (int i = 0; i < 16; i++) begin
            cols_ff[i] <= 16'h0000;
         end
      end else begin
         if (issue) begin
            k_ff <= k_ff + 4'd1;
         end
         rk_ff  <= k_ff;
         rin_ff <= in_rng;
         if (rv_ff) begin
            if (orient_ff) begin
               cols_ff[rk_ff] <= {byte_val, 8'h00};
            end else begin
               // bit i of byte k lands at bit 15-k of column word i
               for (int i = 0; i < 8; i++) begin
                  cols_ff[i][~rk_ff] <= byte_val[i];
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/glyph_blit_to_framebuffer.sv
`timescale 1ns / 1ps
`default_nettype none

// Character generator writing glyphs into a banked monochrome frame store.
// Requests: start with req_* fields, taken when start is high and busy low.
// Kinds: draw character, load glyph byte, clear frame, set cursor, read byte.
// Every request gives one response: rsp_valid strobes for a single cycle with
// rsp_read_data and the cursor after the request. The receiver cannot stall.
// Registers are written through csr_valid/csr_ready (always ready), index and
// data; write them only while the block is idle.
// Path from accept to strobe: load, cursor and unused kinds go straight to
// the response, read passes through a read state, return/newline run an
// 8-step remainder of row by glyph width (skipped at zero width), an undrawn
// or off-panel character responds directly, and clear sweeps FRAME_WORDS words.
// A drawn character: width or height glyph reads for glyph fetch, then per
// column a frame read and write, one more read and write if a lower bank is
// hit, and no frame access for a skipped column.
// One request at a time: busy drops with the strobe, so the next request can
// be taken at the edge that ends the strobe cycle.
// After reset the frame store is zeroed by a sweep, one word per cycle,
// with busy high; configuration writes are still taken then.

module glyph_blit_to_framebuffer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_kind,
   input  wire logic [7:0] req_char_code,
   input  wire logic [7:0] req_pixel_row,
   input  wire logic [7:0] req_column,
   input  wire logic [2:0] req_bank,
   input  wire logic [9:0] req_glyph_address,
   input  wire logic [7:0] req_glyph_byte,
   output logic            rsp_valid,
   output logic [7:0]      rsp_read_data,
   output logic [7:0]      rsp_cursor_row,
   output logic [7:0]      rsp_cursor_col,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [3:0] csr_data
);

   localparam int FAW = gbf_pkg::FADDR_W;

   gbf_pkg::state_type state_ff, state_in;

   logic [7:0]     row_ff, row_in;
   logic [7:0]     col_ff, col_in;
   logic           mode_ff;
   logic [3:0]     width_ff;
   logic [3:0]     height_ff;
   logic           orient_ff;
   logic [FAW-1:0] clr_addr_ff, clr_addr_in;
   logic           clr_rsp_ff, clr_rsp_in;
   logic [3:0]     col_i_ff, col_i_in;
   logic           rd_ok_ff, rd_ok_in;
   logic [7:0]     read_hold_ff, read_hold_in;
   logic [3:0]     rem_ff, rem_in;
   logic [7:0]     div_q_ff, div_q_in;
   logic [2:0]     div_cnt_ff, div_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic [7:0]     rsp_row_ff, rsp_row_in;
   logic [7:0]     rsp_col_ff, rsp_col_in;

   logic [7:0] frame_mem [gbf_pkg::FRAME_WORDS];
   logic [7:0] frd_q;
   logic           frd_en;
   logic [FAW-1:0] frd_addr;
   logic           fwr_en;
   logic [FAW-1:0] fwr_addr;
   logic [7:0]     fwr_data;

   gbf_pkg::glyph_load_type gload;
   gbf_pkg::gather_cmd_type gcmd;
   logic                    g_done;
   logic [15:0]             col_word;

   logic           is_nl, is_cr, off_panel, drawable;
   logic [8:0]     cur_col;
   logic           col_in_range;
   logic [4:0]     bank_idx, phys_hi;
   logic [2:0]     off;
   logic [FAW-1:0] hi_addr, lo_addr, rd_addr;
   logic           lo_needed;
   logic           rd_in_range;
   logic [15:0]    mask_w, data_w;
   logic [7:0]     hi_new, lo_new;
   logic [4:0]     div_t, div_r;

   gbf_glyph_unit u_glyph (
      .clock    (clock),
      .reset    (reset),
      .load     (gload),
      .cmd      (gcmd),
      .col_sel  (col_i_ff),
      .done     (g_done),
      .col_word (col_word)
   );

   always_ff @(posedge clock) begin
      if (fwr_en) begin
         frame_mem[fwr_addr] <= fwr_data;
      end
      if (frd_en) begin
         frd_q <= frame_mem[frd_addr];
      end
   end

   // shared decode and merge datapath
   always_comb begin
      is_nl     = req_char_code == gbf_pkg::CHAR_NEWLINE;
      is_cr     = req_char_code == gbf_pkg::CHAR_RETURN;
      off_panel = ({1'b0, row_ff} >= 9'(gbf_pkg::FRAME_ROWS)) ||
                  ({1'b0, col_ff} >= 9'(gbf_pkg::FRAME_COLUMNS));
      drawable  = (req_char_code >= gbf_pkg::CHAR_FIRST) &&
                  (req_char_code <= gbf_pkg::CHAR_LAST);

      cur_col      = {1'b0, col_ff} + 9'(col_i_ff);
      col_in_range = cur_col < 9'(gbf_pkg::FRAME_COLUMNS);
      bank_idx     = row_ff[7:3];
      off          = row_ff[2:0];
      // panel is rotated: bank 0 of the cursor is the last physical bank
      phys_hi      = 5'(gbf_pkg::FRAME_BANKS - 1) - bank_idx;
      hi_addr      = FAW'(phys_hi * FAW'(gbf_pkg::FRAME_COLUMNS)) + FAW'(cur_col);
      lo_addr      = hi_addr - FAW'(gbf_pkg::FRAME_COLUMNS);
      lo_needed    = (off != 3'd0) && (phys_hi != 5'd0);

      rd_in_range  = ({1'b0, req_bank} < 4'(gbf_pkg::FRAME_BANKS)) &&
                     ({1'b0, req_column} < 9'(gbf_pkg::FRAME_COLUMNS));
      rd_addr      = FAW'(req_bank * FAW'(gbf_pkg::FRAME_COLUMNS)) + FAW'(req_column);

      mask_w = gbf_pkg::MASK_WORD >> off;
      data_w = col_word >> off;
      if (mode_ff) begin
         hi_new = frd_q ^ data_w[15:8];
         lo_new = frd_q ^ data_w[7:0];
      end else begin
         hi_new = (frd_q & ~mask_w[15:8]) | data_w[15:8];
         lo_new = (frd_q & ~mask_w[7:0]) | data_w[7:0];
      end

      div_t = {rem_ff, div_q_ff[7]};
      div_r = (div_t >= {1'b0, width_ff}) ? div_t - {1'b0, width_ff} : div_t;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbf_pkg::ST_CLEAR: begin
            if (clr_addr_ff == FAW'(gbf_pkg::FRAME_WORDS - 1)) begin
               state_in = clr_rsp_ff ? gbf_pkg::ST_DONE : gbf_pkg::ST_IDLE;
            end
         end
         gbf_pkg::ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  gbf_pkg::KIND_CHAR: begin
                     if (is_nl || is_cr) begin
                        state_in = (width_ff != 4'd0) ? gbf_pkg::ST_DIV : gbf_pkg::ST_DONE;
                     end else if (!off_panel && drawable) begin
                        state_in = gbf_pkg::ST_GATHER;
                     end else begin
                        state_in = gbf_pkg::ST_DONE;
                     end
                  end
                  gbf_pkg::KIND_CLEAR: state_in = gbf_pkg::ST_CLEAR;
                  gbf_pkg::KIND_READ:  state_in = gbf_pkg::ST_READ;
                  default:             state_in = gbf_pkg::ST_DONE;
               endcase
            end
         end
         gbf_pkg::ST_GATHER: begin
            if (g_done) begin
               state_in = gbf_pkg::ST_COL;
            end
         end
         gbf_pkg::ST_COL: begin
            if (col_i_ff == height_ff) begin
               state_in = gbf_pkg::ST_DONE;
            end else if (col_in_range) begin
               state_in = gbf_pkg::ST_WR_HI;
            end
         end
         gbf_pkg::ST_WR_HI: state_in = lo_needed ? gbf_pkg::ST_WR_LO : gbf_pkg::ST_COL;
         gbf_pkg::ST_WR_LO: state_in = gbf_pkg::ST_COL;
         gbf_pkg::ST_DIV: begin
            if (div_cnt_ff == 3'd7) begin
               state_in = gbf_pkg::ST_DONE;
            end
         end
         gbf_pkg::ST_READ: state_in = gbf_pkg::ST_DONE;
         gbf_pkg::ST_DONE: state_in = gbf_pkg::ST_IDLE;
         default:          state_in = gbf_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath register updates
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      clr_addr_in  = clr_addr_ff;
      clr_rsp_in   = clr_rsp_ff;
      col_i_in     = col_i_ff;
      rd_ok_in     = rd_ok_ff;
      read_hold_in = read_hold_ff;
      rem_in       = rem_ff;
      div_q_in     = div_q_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      frd_en       = 1'b0;
      frd_addr     = hi_addr;
      fwr_en       = 1'b0;
      fwr_addr     = hi_addr;
      fwr_data     = hi_new;
      gload        = '0;
      gcmd         = '0;
      gcmd.orient  = orient_ff;
      gcmd.width   = width_ff;
      gcmd.height  = height_ff;
      gcmd.code_ofs = 7'(req_char_code - gbf_pkg::CHAR_FIRST);
      busy         = state_ff != gbf_pkg::ST_IDLE;

      case (state_ff)
         gbf_pkg::ST_CLEAR: begin
            fwr_en      = 1'b1;
            fwr_addr    = clr_addr_ff;
            fwr_data    = 8'h00;
            clr_addr_in = clr_addr_ff + FAW'(1);
         end
         gbf_pkg::ST_IDLE: begin
            if (start) begin
               read_hold_in = 8'h00;
               case (req_kind)
                  gbf_pkg::KIND_CHAR: begin
                     if (is_nl || is_cr) begin
                        if (is_nl) begin
                           col_in = col_ff + 8'(height_ff);
                        end
                        rem_in     = 4'd0;
                        div_q_in   = row_ff;
                        div_cnt_in = 3'd0;
                     end else if (!off_panel) begin
                        if (drawable) begin
                           gcmd.start = 1'b1;
                           col_i_in   = 4'd0;
                        end else begin
                           row_in = row_ff + 8'(width_ff);
                        end
                     end
                  end
                  gbf_pkg::KIND_LOAD: begin
                     gload.en   = req_glyph_address <
                                  10'(gbf_pkg::GLYPH_STORE_DEPTH);
                     gload.addr = gbf_pkg::GLYPH_AW'(req_glyph_address);
                     gload.data = req_glyph_byte;
                  end
                  gbf_pkg::KIND_CLEAR: begin
                     row_in      = 8'd0;
                     col_in      = 8'd0;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                  end
                  gbf_pkg::KIND_CURSOR: begin
                     row_in = req_pixel_row;
                     col_in = req_column;
                  end
                  gbf_pkg::KIND_READ: begin
                     rd_ok_in = rd_in_range;
                     frd_en   = rd_in_range;
                     frd_addr = rd_addr;
                  end
                  default: begin
                  end
               endcase
            end
         end
         gbf_pkg::ST_GATHER: begin
         end
         gbf_pkg::ST_COL: begin
            if (col_i_ff == height_ff) begin
               row_in = row_ff + 8'(width_ff);
            end else if (!col_in_range) begin
               col_i_in = col_i_ff + 4'd1;
            end else begin
               frd_en   = 1'b1;
               frd_addr = hi_addr;
            end
         end
         gbf_pkg::ST_WR_HI: begin
            fwr_en   = 1'b1;
            fwr_addr = hi_addr;
            fwr_data = hi_new;
            if (lo_needed) begin
               frd_en   = 1'b1;
               frd_addr = lo_addr;
            end else begin
               col_i_in = col_i_ff + 4'd1;
            end
         end
         gbf_pkg::ST_WR_LO: begin
            fwr_en   = 1'b1;
            fwr_addr = lo_addr;
            fwr_data = lo_new;
            col_i_in = col_i_ff + 4'd1;
         end
         gbf_pkg::ST_DIV: begin
            // restoring remainder, one dividend bit per cycle
            rem_in     = div_r[3:0];
            div_q_in   = {div_q_ff[6:0], 1'b0};
            div_cnt_in = div_cnt_ff + 3'd1;
            if (div_cnt_ff == 3'd7) begin
               row_in = {4'd0, div_r[3:0]};
            end
         end
         gbf_pkg::ST_READ: begin
            read_hold_in = rd_ok_ff ? frd_q : 8'h00;
         end
         gbf_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = read_hold_ff;
            rsp_row_in   = row_ff;
            rsp_col_in   = col_ff;
            clr_rsp_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbf_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         row_ff       <= 8'd0;
         col_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         width_ff     <= 4'd5;
         height_ff    <= 4'd8;
         orient_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gbf_pkg::CSR_DRAW_MODE:    mode_ff   <= csr_data[0];
               gbf_pkg::CSR_GLYPH_WIDTH:  width_ff  <= csr_data;
               gbf_pkg::CSR_GLYPH_HEIGHT: height_ff <= csr_data;
               gbf_pkg::CSR_GLYPH_ORIENT: orient_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      col_i_ff     <= col_i_in;
      rd_ok_ff     <= rd_ok_in;
      read_hold_ff <= read_hold_in;
      rem_ff       <= rem_in;
      div_q_ff     <= div_q_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;

endmodule

`default_nettype wire
